// ----- rtl/core/fgwd_pkg.sv -----
// Shared types, widths, codes and reset values for the flex gesture window detector.
// No dependencies; every other file imports this package.
package fgwd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TH_BITS     = 10;
  localparam int CMP_BITS    = (SAMPLE_BITS > TH_BITS) ? SAMPLE_BITS : TH_BITS;
  localparam int DEB_BITS    = 8;
  localparam int MS_BITS     = 16;
  localparam int TIME_BITS   = 32;

  localparam int IN_RAW_W    = 2 * SAMPLE_BITS + TIME_BITS;
  localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 4;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TH_HIGH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TH_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_WIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_WIN = 3'd5;

  localparam logic [TH_BITS-1:0]  RST_TH_HIGH    = TH_BITS'(500);
  localparam logic [TH_BITS-1:0]  RST_TH_LOW     = TH_BITS'(200);
  localparam logic [DEB_BITS-1:0] RST_DEBOUNCE   = DEB_BITS'(3);
  localparam logic [MS_BITS-1:0]  RST_CLOSE_HOLD = MS_BITS'(150);
  localparam logic [MS_BITS-1:0]  RST_OPEN_WIN   = MS_BITS'(300);
  localparam logic [MS_BITS-1:0]  RST_REPORT_WIN = MS_BITS'(2000);

  localparam logic [1:0] GEST_NONE  = 2'd0;
  localparam logic [1:0] GEST_OPEN  = 2'd1;
  localparam logic [1:0] GEST_CLOSE = 2'd2;
  localparam logic [1:0] GEST_START = 2'd3;

  localparam logic [1:0] PAT_LOW   = 2'b00;
  localparam logic [1:0] PAT_START = 2'b10;
  localparam logic [1:0] PAT_HIGH  = 2'b11;

  typedef struct packed {
    logic [TH_BITS-1:0]  th_high;
    logic [TH_BITS-1:0]  th_low;
    logic [DEB_BITS-1:0] debounce;
    logic [MS_BITS-1:0]  close_hold;
    logic [MS_BITS-1:0]  open_win;
    logic [MS_BITS-1:0]  report_win;
  } cfg_t;

  typedef struct packed {
    logic       window_ended;
    logic [1:0] gesture;
    logic [1:0] stable_pattern;
  } result_t;

endpackage

// ----- rtl/core/flex_gesture_window_detector_unit.sv -----
// Top level: config registers, two sensor lanes, merge stage, output register + skid.
// Depends on fgwd_pkg, fgwd_lane, fgwd_merge.
//
//  channel | ports                          | request fields (low bit first)
//  --------+--------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | sample_a, sample_b, now_ms
//  out     | out_tvalid/out_tready/out_tdata| stable_pattern, gesture; tlast=window_ended
//  cfg     | cfg_valid/cfg_ready            | cfg_index, cfg_data (always ready)
//
// One request per cycle while in_tready is high; results pass through the output register.
// Lanes and merge update all state in the accepting cycle, so the loop through the
// 32-bit time compares sets the clock. A skid entry behind the output register keeps
// in_tready high for one request while out_tready is low. Synchronous reset restores
// register defaults and detector state; no clearing pass.
module flex_gesture_window_detector_unit import fgwd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_a, sample_b, now_ms, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // stable_pattern, gesture, zero pad
  output logic                  out_tlast,  // window_ended
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  logic    in_fire, out_fire;
  logic    stable_a, stable_b;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.th_high    <= RST_TH_HIGH;
      cfg_r.th_low     <= RST_TH_LOW;
      cfg_r.debounce   <= RST_DEBOUNCE;
      cfg_r.close_hold <= RST_CLOSE_HOLD;
      cfg_r.open_win   <= RST_OPEN_WIN;
      cfg_r.report_win <= RST_REPORT_WIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TH_HIGH:    cfg_r.th_high    <= TH_BITS'(cfg_data);
        REG_TH_LOW:     cfg_r.th_low     <= TH_BITS'(cfg_data);
        REG_DEBOUNCE:   cfg_r.debounce   <= DEB_BITS'(cfg_data);
        REG_CLOSE_HOLD: cfg_r.close_hold <= MS_BITS'(cfg_data);
        REG_OPEN_WIN:   cfg_r.open_win   <= MS_BITS'(cfg_data);
        REG_REPORT_WIN: cfg_r.report_win <= MS_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  fgwd_lane u_lane_a (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .sample       (in_tdata[SAMPLE_BITS-1:0]),
    .cfg          (cfg_r),
    .stable_nxt_o (stable_a)
  );

  fgwd_lane u_lane_b (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .sample       (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .cfg          (cfg_r),
    .stable_nxt_o (stable_b)
  );

  fgwd_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .pattern ({stable_a, stable_b}),
    .now_ms  (in_tdata[IN_RAW_W-1:2*SAMPLE_BITS]),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_RAW_W)'(0), out_data_r.gesture,
                       out_data_r.stable_pattern};
  assign out_tlast  = out_data_r.window_ended;

endmodule

// ----- rtl/core/fgwd_lane.sv -----
// One sensor lane: hysteresis comparator followed by the debounce counter.
// Depends on fgwd_pkg.
module fgwd_lane import fgwd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  cfg_t                   cfg,
  output logic                   stable_nxt_o
);

  logic                raw_r, raw_nxt;
  logic                stable_r, stable_nxt;
  logic [DEB_BITS-1:0] count_r, count_nxt;
  logic [DEB_BITS-1:0] count_inc;
  logic [CMP_BITS-1:0] s_ext, hi_ext, lo_ext;

  assign s_ext     = CMP_BITS'(sample);
  assign hi_ext    = CMP_BITS'(cfg.th_high);
  assign lo_ext    = CMP_BITS'(cfg.th_low);
  assign count_inc = count_r + DEB_BITS'(1);

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    count_nxt  = '0;
    if (s_ext > hi_ext) begin
      raw_nxt = 1'b1;
    end else if (s_ext < lo_ext) begin
      raw_nxt = 1'b0;
    end
    if (raw_nxt != stable_r) begin
      if (count_inc >= cfg.debounce) begin
        stable_nxt = raw_nxt;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  assign stable_nxt_o = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b1;
      stable_r <= 1'b1;
      count_r  <= '0;
    end else if (accept) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/fgwd_merge.sv -----
// Merge stage: pattern tracking, START/CLOSE/OPEN flags and report window.
// Depends on fgwd_pkg.
module fgwd_merge import fgwd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           pattern,
  input  logic [TIME_BITS-1:0] now_ms,
  input  cfg_t                 cfg,
  output result_t              res
);

  logic [1:0]           prev_pat_r;
  logic                 in_low_r, in_low_nxt;
  logic [TIME_BITS-1:0] low_enter_r, low_enter_nxt;
  logic [TIME_BITS-1:0] last_close_r, last_close_nxt;
  logic                 close_done_r, close_done_nxt;
  logic                 high_seen_r, high_seen_nxt;
  logic [TIME_BITS-1:0] win_start_r, win_start_nxt;
  logic                 f_close_r, f_close_nxt;
  logic                 f_open_r, f_open_nxt;
  logic                 f_start_r, f_start_nxt;
  logic                 fc, fo, fs, ended;
  logic [1:0]           gesture;
  logic [TIME_BITS-1:0] low_age, close_age, win_age;

  assign low_age   = now_ms - low_enter_nxt;
  assign close_age = now_ms - last_close_r;
  assign win_age   = now_ms - win_start_r;

  always_comb begin
    in_low_nxt     = in_low_r;
    low_enter_nxt  = low_enter_r;
    close_done_nxt = close_done_r;
    last_close_nxt = last_close_r;
    high_seen_nxt  = high_seen_r;
    fs = f_start_r | ((pattern == PAT_START) && (prev_pat_r != PAT_START));
    fc = f_close_r;
    fo = f_open_r;

    if (pattern == PAT_LOW) begin
      if (!in_low_r) begin
        in_low_nxt     = 1'b1;
        low_enter_nxt  = now_ms;
        close_done_nxt = 1'b0;
      end
    end else begin
      in_low_nxt     = 1'b0;
      close_done_nxt = 1'b0;
    end
    if ((pattern == PAT_LOW) && (low_age >= TIME_BITS'(cfg.close_hold)) && !close_done_nxt)
    begin
      fc             = 1'b1;
      close_done_nxt = 1'b1;
      last_close_nxt = now_ms;
    end

    if (pattern == PAT_HIGH) begin
      if (!high_seen_r) begin
        if (close_age < TIME_BITS'(cfg.open_win)) fo = 1'b1;
        high_seen_nxt = 1'b1;
      end
    end else begin
      high_seen_nxt = 1'b0;
    end

    ended         = (win_age >= TIME_BITS'(cfg.report_win));
    gesture       = GEST_NONE;
    win_start_nxt = win_start_r;
    f_open_nxt    = fo;
    f_close_nxt   = fc;
    f_start_nxt   = fs;
    if (ended) begin
      priority if (fo) gesture = GEST_OPEN;
      else if (fc)     gesture = GEST_CLOSE;
      else if (fs)     gesture = GEST_START;
      win_start_nxt = now_ms;
      f_open_nxt    = 1'b0;
      f_close_nxt   = 1'b0;
      f_start_nxt   = 1'b0;
    end
  end

  assign res.stable_pattern = pattern;
  assign res.gesture        = gesture;
  assign res.window_ended   = ended;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pat_r   <= PAT_HIGH;
      in_low_r     <= 1'b0;
      low_enter_r  <= '0;
      last_close_r <= '0;
      close_done_r <= 1'b0;
      high_seen_r  <= 1'b0;
      win_start_r  <= '0;
      f_close_r    <= 1'b0;
      f_open_r     <= 1'b0;
      f_start_r    <= 1'b0;
    end else if (accept) begin
      prev_pat_r   <= pattern;
      in_low_r     <= in_low_nxt;
      low_enter_r  <= low_enter_nxt;
      last_close_r <= last_close_nxt;
      close_done_r <= close_done_nxt;
      high_seen_r  <= high_seen_nxt;
      win_start_r  <= win_start_nxt;
      f_close_r    <= f_close_nxt;
      f_open_r     <= f_open_nxt;
      f_start_r    <= f_start_nxt;
    end
  end

endmodule

// ----- rtl/core/fgwd_checker.sv -----
// Port-level checks for the detector top level, attached by bind.
// Depends on fgwd_pkg and flex_gesture_window_detector_unit.
module fgwd_checker import fgwd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a gesture is only reported on the request that ends a window
  a_gesture_at_window_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:2] != GEST_NONE)) |-> out_tlast)
    else $error("gesture reported outside window end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // skid entry is only occupied while the output register is full
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output request changed");

endmodule

bind flex_gesture_window_detector_unit fgwd_checker u_fgwd_checker (.*);

// ----- sim/flex_gesture_window_detector_unit_tb.sv -----
// Self-checking testbench for flex_gesture_window_detector_unit: directed table, then random
// sensor sequences under several register settings, with random input gaps and output stalls.
// Depends on fgwd_pkg and the RTL top level only.
module flex_gesture_window_detector_unit_tb;
  import fgwd_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam result_t NO_REPORT = '0;

  localparam cfg_t CFG_DEFAULT = '{RST_TH_HIGH, RST_TH_LOW, RST_DEBOUNCE,
                                   RST_CLOSE_HOLD, RST_OPEN_WIN, RST_REPORT_WIN};
  localparam cfg_t CFG_FLOOR = '{10'd0, 10'd1023, 8'd0, 16'd0, 16'd0, 16'd0};
  localparam cfg_t CFG_CEIL  = '{10'd1023, 10'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF};

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sa;
    logic [SAMPLE_BITS-1:0] sb;
    logic [TIME_BITS-1:0]   now;
    logic                   typed;
    result_t                want;
  } row_t;

  // typed rows: open before any close, then its report at window end
  localparam row_t DIR_ROWS [28] = '{
    '{10'd1023, 10'd1023, 32'd0,    1'b1, '{1'b0, GEST_NONE, PAT_HIGH}},
    '{10'd1023, 10'd1023, 32'd2000, 1'b1, '{1'b1, GEST_OPEN, PAT_HIGH}},
    '{10'd1023, 10'd0,    32'd2010, 1'b0, NO_REPORT},
    '{10'd1023, 10'd300,  32'd2020, 1'b0, NO_REPORT},
    '{10'd1023, 10'd200,  32'd2030, 1'b0, NO_REPORT},
    '{10'd501,  10'd199,  32'd2040, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd2050, 1'b0, NO_REPORT},
    '{10'd199,  10'd0,    32'd2060, 1'b0, NO_REPORT},
    '{10'd500,  10'd0,    32'd2070, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd2100, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd2220, 1'b0, NO_REPORT},
    '{10'd1023, 10'd1023, 32'd2230, 1'b0, NO_REPORT},
    '{10'd1023, 10'd1023, 32'd2240, 1'b0, NO_REPORT},
    '{10'd1023, 10'd1023, 32'd2250, 1'b0, NO_REPORT},
    '{10'd1023, 10'd1023, 32'd4000, 1'b0, NO_REPORT},
    '{10'd0,    10'd1023, 32'd4010, 1'b0, NO_REPORT},
    '{10'd0,    10'd1023, 32'd4020, 1'b0, NO_REPORT},
    '{10'd0,    10'd1023, 32'd4030, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd4040, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd4050, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd4060, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd4210, 1'b0, NO_REPORT},
    '{10'd0,    10'd0,    32'd6000, 1'b0, NO_REPORT},
    '{10'd1023, 10'd0,    32'd6010, 1'b0, NO_REPORT},
    '{10'd1023, 10'd0,    32'd6020, 1'b0, NO_REPORT},
    '{10'd1023, 10'd0,    32'd6030, 1'b0, NO_REPORT},
    '{10'd1023, 10'd0,    32'hFFFF_FFF0, 1'b0, NO_REPORT},
    '{10'd1023, 10'd1023, 32'h0000_07E0, 1'b0, NO_REPORT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flex_gesture_window_detector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // detector shadow state
  cfg_t           regs_m;
  logic           raw_l [2];
  logic           stb_l [2];
  logic [7:0]     deb_c [2];
  logic [1:0]     last_pat;
  logic           low_phase, close_done, high_seen;
  logic           f_open, f_close, f_start;
  logic [31:0]    low_since, close_at, window_at;

  result_t        pending_reports [$];
  int             mismatches = 0;
  int             cycle_cnt = 0;
  int             burst_left = 0;
  bit             steady_send = 1'b0;
  rx_mode_e       rx_mode = RX_OPEN;
  int             rx_left = 0;

  function automatic void reset_model();
    regs_m = CFG_DEFAULT;
    for (int c = 0; c < 2; c++) begin
      raw_l[c] = 1'b1;
      stb_l[c] = 1'b1;
      deb_c[c] = '0;
    end
    last_pat = PAT_HIGH;
    low_phase = 1'b0; close_done = 1'b0; high_seen = 1'b0;
    f_open = 1'b0; f_close = 1'b0; f_start = 1'b0;
    low_since = '0; close_at = '0; window_at = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TH_HIGH:    regs_m.th_high    = val[TH_BITS-1:0];
      REG_TH_LOW:     regs_m.th_low     = val[TH_BITS-1:0];
      REG_DEBOUNCE:   regs_m.debounce   = val[DEB_BITS-1:0];
      REG_CLOSE_HOLD: regs_m.close_hold = val[MS_BITS-1:0];
      REG_OPEN_WIN:   regs_m.open_win   = val[MS_BITS-1:0];
      REG_REPORT_WIN: regs_m.report_win = val[MS_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void level_step(input int c, input logic [SAMPLE_BITS-1:0] v);
    if (v > regs_m.th_high) raw_l[c] = 1'b1;
    else if (v < regs_m.th_low) raw_l[c] = 1'b0;
    if (raw_l[c] != stb_l[c]) begin
      deb_c[c] = deb_c[c] + 8'd1;
      if (deb_c[c] >= regs_m.debounce) begin
        stb_l[c] = raw_l[c];
        deb_c[c] = '0;
      end
    end else begin
      deb_c[c] = '0;
    end
  endfunction

  function automatic result_t gesture_step(input logic [SAMPLE_BITS-1:0] sa,
                                           input logic [SAMPLE_BITS-1:0] sb,
                                           input logic [31:0] now);
    result_t r;
    logic [1:0] pat;
    r = '0;
    level_step(0, sa);
    level_step(1, sb);
    pat = {stb_l[0], stb_l[1]};
    if (pat == PAT_START && last_pat != PAT_START) f_start = 1'b1;
    if (pat == PAT_LOW) begin
      if (!low_phase) begin
        low_phase = 1'b1;
        low_since = now;
        close_done = 1'b0;
      end
      if (32'(now - low_since) >= 32'(regs_m.close_hold) && !close_done) begin
        f_close = 1'b1;
        close_done = 1'b1;
        close_at = now;
      end
    end else begin
      low_phase = 1'b0;
      close_done = 1'b0;
    end
    if (pat == PAT_HIGH) begin
      if (!high_seen) begin
        if (32'(now - close_at) < 32'(regs_m.open_win)) f_open = 1'b1;
        high_seen = 1'b1;
      end
    end else begin
      high_seen = 1'b0;
    end
    r.gesture = GEST_NONE;
    if (32'(now - window_at) >= 32'(regs_m.report_win)) begin
      r.window_ended = 1'b1;
      if (f_open) r.gesture = GEST_OPEN;
      else if (f_close) r.gesture = GEST_CLOSE;
      else if (f_start) r.gesture = GEST_START;
      window_at = now;
      f_open = 1'b0; f_close = 1'b0; f_start = 1'b0;
    end
    last_pat = pat;
    r.stable_pattern = pat;
    return r;
  endfunction

  // sample that should land on the given level under the current thresholds, with some noise
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic lvl);
    int hi, lo, r;
    hi = regs_m.th_high;
    lo = regs_m.th_low;
    r = $urandom_range(0, 15);
    if (r == 0) return SAMPLE_BITS'($urandom);
    if (r == 1) return SAMPLE_BITS'($urandom_range(lo, hi));
    if (lvl) return (hi >= 1023) ? 10'd1023 : SAMPLE_BITS'($urandom_range(1023, hi + 1));
    if (lo == 0) return 10'd0;
    return SAMPLE_BITS'($urandom_range((lo > hi) ? hi : lo - 1, 0));
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    int lo;
    lo = $urandom_range(20, 600);
    c.th_low = TH_BITS'(lo);
    if ($urandom_range(0, 7) == 0) c.th_high = TH_BITS'($urandom_range(lo, 0));
    else c.th_high = TH_BITS'((lo + $urandom_range(0, 400) > 1023) ? 1023
                                : lo + $urandom_range(0, 400));
    c.debounce = ($urandom_range(0, 7) == 0) ? DEB_BITS'($urandom_range(0, 255))
                                             : DEB_BITS'($urandom_range(1, 6));
    c.close_hold = MS_BITS'($urandom_range(0, 400));
    c.open_win   = MS_BITS'($urandom_range(0, 800));
    c.report_win = MS_BITS'($urandom_range(1, 2500));
    return c;
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sa, input logic [SAMPLE_BITS-1:0] sb,
                             input logic [31:0] now, input logic typed, input result_t want);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_send ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({now, sb, sa});
    do @(posedge clk); while (!in_tready);
    r = gesture_step(sa, sb, now);
    pending_reports.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // upper data bits beyond each register's width are junk and must be dropped
  task automatic load_regs(input cfg_t c);
    write_reg(REG_TH_HIGH,    {6'($urandom), c.th_high});
    write_reg(REG_TH_LOW,     {6'($urandom), c.th_low});
    write_reg(REG_DEBOUNCE,   {8'($urandom), c.debounce});
    write_reg(REG_CLOSE_HOLD, c.close_hold);
    write_reg(REG_OPEN_WIN,   c.open_win);
    write_reg(REG_REPORT_WIN, c.report_win);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= cycle_cnt[2];
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected request: tdata %h tlast %b", $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[1:0] != want.stable_pattern) begin
          $display("%0t stable_pattern exp %0d got %0d", $time, want.stable_pattern,
                   out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[3:2] != want.gesture) begin
          $display("%0t gesture exp %0d got %0d", $time, want.gesture, out_tdata[3:2]);
          mismatches++;
        end
        if (out_tlast != want.window_ended) begin
          $display("%0t window_ended exp %0d got %0d", $time, want.window_ended, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic lvl_a, lvl_b;
    int n;
    cfg_t pc;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i])
      send_sample(DIR_ROWS[i].sa, DIR_ROWS[i].sb, DIR_ROWS[i].now,
                  DIR_ROWS[i].typed, DIR_ROWS[i].want);

    for (int p = 1; p <= 8; p++) begin
      drain();
      case (p)
        1: pc = CFG_FLOOR;
        2: pc = CFG_CEIL;
        3: pc = CFG_DEFAULT;
        default: pc = random_regs();
      endcase
      load_regs(pc);
      steady_send = ($urandom_range(0, 3) == 0);
      n = (p <= 2) ? 120 : 260;
      clock_ms = $urandom;
      lvl_a = 1'b1;
      lvl_b = 1'b1;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) lvl_a = ~lvl_a;
        if ($urandom_range(0, 9) == 0) lvl_b = ~lvl_b;
        if ($urandom_range(0, 59) == 0) clock_ms = $urandom;
        else if ($urandom_range(0, 19) == 0) clock_ms += $urandom_range(0, 3000);
        else clock_ms += $urandom_range(0, 40);
        send_sample(pick_sample(lvl_a), pick_sample(lvl_b), clock_ms, 1'b0, NO_REPORT);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fgwd_pkg.sv
rtl/core/fgwd_lane.sv
rtl/core/fgwd_merge.sv
rtl/core/flex_gesture_window_detector_unit.sv
rtl/core/fgwd_checker.sv
sim/flex_gesture_window_detector_unit_tb.sv
